>>> hdl/indexed_sequential_list_defines.svh
// Assertion macros for the indexed sequential list.
// Depends on nothing; the asserting modules supply i_clk and i_rst_n.
`ifndef INDEXED_SEQUENTIAL_LIST_DEFINES_SVH
`define INDEXED_SEQUENTIAL_LIST_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property at each clock edge outside reset.
`define ISL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check a property at every clock edge, reset included.
`define ISL_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`else

`define ISL_ASSERT(label, prop, msg)
`define ISL_ASSERT_RST(label, prop, msg)

`endif

`endif

>>> hdl/isl_pkg.sv
// Shared types and constants of the indexed sequential list.
// Depends on nothing; used by the interfaces, the engine and the top level.
package isl_pkg;

    localparam int DEPTH  = 32;
    localparam int AW     = $clog2(DEPTH);
    localparam int LEN_W  = $clog2(DEPTH + 1);
    localparam int FUNC_W = 3;
    localparam int POS_W  = 6;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 6;
    localparam int CMP_W  = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;

    typedef enum logic [FUNC_W-1:0] {
        F_INSERT = 3'd0,
        F_UPDATE = 3'd1,
        F_DELETE = 3'd2,
        F_CLEAR  = 3'd3,
        F_READ   = 3'd4
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        EO_INSERT = 2'd0,
        EO_DELETE = 2'd1,
        EO_WRITE  = 2'd2,
        EO_READ   = 2'd3
    } t_eng_op;

    typedef struct packed {
        logic             valid;
        t_eng_op          op;
        logic [AW-1:0]    src;
        logic [LEN_W-1:0] left;
        logic [AW-1:0]    addr;
        logic [VAL_W-1:0] value;
    } t_eng_cmd;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] data;
    } t_eng_rsp;

endpackage

>>> hdl/isl_if.sv
// Request and response channels of the indexed sequential list.
// Depends on isl_pkg for the field widths.
interface isl_req_if import isl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  position;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output func, output position, output value, input ready);
    modport sink   (input valid, input func, input position, input value, output ready);
endinterface

interface isl_rsp_if import isl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
    logic signed [VAL_W-1:0] read_value;

    modport source (output valid, output status, output count, output read_value, input ready);
    modport sink   (input valid, input status, input count, input read_value, output ready);
endinterface

>>> hdl/isl_engine.sv
// Entry store and shift sequencer of the indexed sequential list.
// Depends on isl_pkg and indexed_sequential_list_defines.svh.
`include "indexed_sequential_list_defines.svh"

module isl_engine import isl_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_eng_cmd i_cmd,
    output t_eng_rsp o_rsp
);

    typedef enum logic [3:0] {
        E_IDLE  = 4'b0001,
        E_SHIFT = 4'b0010,
        E_PUT   = 4'b0100,
        E_FETCH = 4'b1000
    } t_eng_state;

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_q;

    t_eng_state       r_state, n_state;
    logic             r_pend,  n_pend;
    logic             r_up,    n_up;
    logic             r_put,   n_put;
    logic [AW-1:0]    r_src,   n_src;
    logic [AW-1:0]    r_dst,   n_dst;
    logic [LEN_W-1:0] r_left,  n_left;
    logic [AW-1:0]    r_addr,  n_addr;
    logic [VAL_W-1:0] r_value, n_value;

    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [VAL_W-1:0] mem_wd;
    logic [AW-1:0]    mem_ra;

    always_comb begin
        n_state    = r_state;
        n_pend     = r_pend;
        n_up       = r_up;
        n_put      = r_put;
        n_src      = r_src;
        n_dst      = r_dst;
        n_left     = r_left;
        n_addr     = r_addr;
        n_value    = r_value;
        mem_we     = 1'b0;
        mem_wa     = r_dst;
        mem_wd     = r_q;
        mem_ra     = r_src;
        o_rsp.done = 1'b0;
        o_rsp.data = r_q;

        case (r_state)
            E_IDLE: begin
                if (i_cmd.valid) begin
                    n_src   = i_cmd.src;
                    n_left  = i_cmd.left;
                    n_addr  = i_cmd.addr;
                    n_value = i_cmd.value;
                    n_up    = (i_cmd.op == EO_DELETE);
                    n_put   = (i_cmd.op == EO_INSERT);
                    n_pend  = 1'b0;
                    case (i_cmd.op)
                        EO_INSERT, EO_DELETE: n_state = E_SHIFT;
                        EO_WRITE:             n_state = E_PUT;
                        EO_READ: begin
                            mem_ra  = i_cmd.addr;
                            n_state = E_FETCH;
                        end
                        default:              n_state = E_IDLE;
                    endcase
                end
            end
            E_SHIFT: begin
                // write back the entry read in the previous cycle
                if (r_pend) begin
                    mem_we = 1'b1;
                end
                if (r_left != '0) begin
                    n_src  = r_up ? r_src + AW'(1) : r_src - AW'(1);
                    n_dst  = r_up ? r_src - AW'(1) : r_src + AW'(1);
                    n_left = r_left - LEN_W'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        if (r_put) begin
                            n_state = E_PUT;
                        end else begin
                            o_rsp.done = 1'b1;
                            n_state    = E_IDLE;
                        end
                    end
                end
            end
            E_PUT: begin
                mem_we     = 1'b1;
                mem_wa     = r_addr;
                mem_wd     = r_value;
                o_rsp.done = 1'b1;
                n_state    = E_IDLE;
            end
            E_FETCH: begin
                o_rsp.done = 1'b1;
                n_state    = E_IDLE;
            end
            default: begin
                n_state = E_IDLE;
            end
        endcase
    end

    // Store contents outside the list are never visible, so the array needs no clearing.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_q <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_up    <= n_up;
        r_put   <= n_put;
        r_src   <= n_src;
        r_dst   <= n_dst;
        r_left  <= n_left;
        r_addr  <= n_addr;
        r_value <= n_value;
    end

    `ISL_ASSERT(a_shift_count, (r_state == E_SHIFT && r_left != '0) |=> (r_left == $past(r_left) - LEN_W'(1)), "shift count did not advance")
    `ISL_ASSERT(a_done_idle, o_rsp.done |=> (r_state == E_IDLE), "engine not idle after done")
    `ISL_ASSERT(a_fetch_entry, (r_state == E_FETCH) |-> ($past(r_state) == E_IDLE), "fetch without a read command")

endmodule

>>> hdl/indexed_sequential_list.sv
// Indexed sequential list: insert, update, delete, clear and read at 1-based positions.
// Clear and rejected items bypass the engine; insert and delete shift the tail of the list.
// One entry moves per cycle; one item at a time, the next taken when its result can leave.
// Synchronous active-low reset empties the list; store contents are not cleared.
`include "indexed_sequential_list_defines.svh"

module indexed_sequential_list import isl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    isl_req_if.sink     i_req,
    isl_rsp_if.source   o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_BUSY = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [LEN_W-1:0]  r_len,   n_len;
    t_status           r_status, n_status;
    logic              r_is_read, n_is_read;
    logic [VAL_W-1:0]  r_rval,  n_rval;

    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_out_status, n_out_status;
    logic [CNT_W-1:0]  r_out_count,  n_out_count;
    logic [VAL_W-1:0]  r_out_rval,   n_out_rval;

    t_eng_cmd          eng_cmd;
    t_eng_rsp          eng_rsp;

    logic              accept;
    logic              load_out;
    logic [CMP_W-1:0]  pos_x;
    logic [CMP_W-1:0]  len_x;
    logic              pos_ok;
    logic              pos_ok_ins;
    logic [CMP_W-1:0]  ins_left;
    logic [CMP_W-1:0]  del_left;
    logic [AW-1:0]     slot;

    isl_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (eng_cmd),
        .o_rsp   (eng_rsp)
    );

    // Take a new item only between items; the output register holds the last result.
    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    // Position checks in a width that holds length + 1.
    assign pos_x      = CMP_W'(i_req.position);
    assign len_x      = CMP_W'(r_len);
    assign pos_ok     = (pos_x != '0) && (pos_x <= len_x);
    assign pos_ok_ins = (pos_x != '0) && (pos_x <= len_x + CMP_W'(1));
    assign ins_left   = len_x - pos_x + CMP_W'(1);
    assign del_left   = len_x - pos_x;
    assign slot       = AW'(i_req.position - POS_W'(1));

    // Load the result once the output register is empty or being drained.
    assign load_out = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state       = r_state;
        n_len         = r_len;
        n_status      = r_status;
        n_is_read     = r_is_read;
        n_rval        = r_rval;
        eng_cmd       = '0;
        eng_cmd.value = i_req.value;
        eng_cmd.addr  = slot;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status  = ST_OK;
                    n_is_read = 1'b0;
                    n_rval    = '0;
                    n_state   = S_DONE;
                    case (i_req.func)
                        F_INSERT: begin
                            // full check wins over the position check
                            if (r_len == LEN_W'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else if (!pos_ok_ins) begin
                                n_status = ST_RANGE;
                            end else begin
                                eng_cmd.valid = 1'b1;
                                eng_cmd.op    = EO_INSERT;
                                eng_cmd.src   = AW'(r_len - LEN_W'(1));
                                eng_cmd.left  = LEN_W'(ins_left);
                                n_len         = r_len + LEN_W'(1);
                                n_state       = S_BUSY;
                            end
                        end
                        F_UPDATE: begin
                            if (!pos_ok) begin
                                n_status = ST_RANGE;
                            end else begin
                                eng_cmd.valid = 1'b1;
                                eng_cmd.op    = EO_WRITE;
                                n_state       = S_BUSY;
                            end
                        end
                        F_DELETE: begin
                            if (!pos_ok) begin
                                n_status = ST_RANGE;
                            end else begin
                                eng_cmd.valid = 1'b1;
                                eng_cmd.op    = EO_DELETE;
                                eng_cmd.src   = AW'(i_req.position);
                                eng_cmd.left  = LEN_W'(del_left);
                                n_len         = r_len - LEN_W'(1);
                                n_state       = S_BUSY;
                            end
                        end
                        F_CLEAR: begin
                            // entries past the length are never read, so drop the length only
                            n_len = '0;
                        end
                        F_READ: begin
                            if (!pos_ok) begin
                                n_status = ST_RANGE;
                            end else begin
                                eng_cmd.valid = 1'b1;
                                eng_cmd.op    = EO_READ;
                                n_is_read     = 1'b1;
                                n_state       = S_BUSY;
                            end
                        end
                        default: begin
                            n_status = ST_RANGE;
                        end
                    endcase
                end
            end
            S_BUSY: begin
                if (eng_rsp.done) begin
                    n_rval  = r_is_read ? eng_rsp.data : '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: hold until taken, refill from the finished item.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_rval   = r_out_rval;
        if (o_rsp.valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        if (load_out) begin
            n_out_valid  = 1'b1;
            n_out_status = r_status;
            n_out_count  = CNT_W'(r_len);
            n_out_rval   = r_rval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status     <= n_status;
        r_is_read    <= n_is_read;
        r_rval       <= n_rval;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_rval   <= n_out_rval;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.count      = r_out_count;
    assign o_rsp.read_value = r_out_rval;

    `ISL_ASSERT_RST(a_rst_idle, !i_rst_n |=> (r_state == S_IDLE && r_len == '0), "not empty after reset")
    `ISL_ASSERT(a_len_bound, r_len <= LEN_W'(DEPTH), "length beyond capacity")
    `ISL_ASSERT(a_len_hold, !(i_req.valid && i_req.ready) |=> $stable(r_len), "length moved without an item")
    `ISL_ASSERT(a_done_busy, eng_rsp.done |-> (r_state == S_BUSY), "engine finished with no item in work")

endmodule

>>> verif/tb_top.sv
// Self-checking bench for the indexed sequential list: directed and random items.
// Depends on isl_pkg, the request/response interfaces in isl_if.sv and the indexed_sequential_list RTL.
module tb_top import isl_pkg::*; ();

    // Operation codes the block does not define; they must come back as range errors.
    localparam logic [FUNC_W-1:0] F_SPARE_LO = 3'd5;
    localparam logic [FUNC_W-1:0] F_SPARE_HI = 3'd7;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int DRAIN_CYCLES = 48;    // longest shift plus handshake slack

    typedef struct {
        t_status                 status;
        logic [CNT_W-1:0]        count;
        logic signed [VAL_W-1:0] read_value;
    } t_list_result;

    // Shadow copy of the list and the results it predicts, oldest first.
    class t_list_shadow;
        logic signed [VAL_W-1:0] slots [DEPTH];
        int                      n_entries;
        t_list_result            expected[$];
        int                      failures;

        function new();
            foreach (slots[k]) slots[k] = '0;
            n_entries = 0;
            failures  = 0;
        endfunction

        // Apply one accepted request to the shadow list and queue its result.
        function void note_request(logic [FUNC_W-1:0] func, logic [POS_W-1:0] pos,
                                   logic signed [VAL_W-1:0] val);
            t_list_result res;
            int p;
            p = pos;
            res.status = ST_OK;
            res.read_value = '0;
            case (func)
                F_INSERT: begin
                    if (n_entries >= DEPTH) begin
                        res.status = ST_FULL;
                    end else if (p < 1 || p > n_entries + 1) begin
                        res.status = ST_RANGE;
                    end else begin
                        for (int k = n_entries; k >= p; k--) slots[k] = slots[k-1];
                        slots[p-1] = val;
                        n_entries++;
                    end
                end
                F_UPDATE: begin
                    if (p < 1 || p > n_entries) res.status = ST_RANGE;
                    else slots[p-1] = val;
                end
                F_DELETE: begin
                    if (p < 1 || p > n_entries) begin
                        res.status = ST_RANGE;
                    end else begin
                        for (int k = p; k < n_entries; k++) slots[k-1] = slots[k];
                        n_entries--;
                    end
                end
                F_CLEAR: begin
                    foreach (slots[k]) slots[k] = '0;
                    n_entries = 0;
                end
                F_READ: begin
                    if (p < 1 || p > n_entries) res.status = ST_RANGE;
                    else res.read_value = slots[p-1];
                end
                default: res.status = ST_RANGE;
            endcase
            res.count = CNT_W'(n_entries);
            expected.push_back(res);
        endfunction

        // Compare one accepted response with the oldest queued result.
        function void check_response(logic [STAT_W-1:0] status, logic [CNT_W-1:0] count,
                                     logic signed [VAL_W-1:0] read_value);
            t_list_result want;
            if (expected.size() == 0) begin
                $error("response with no request pending: status %0d count %0d", status, count);
                failures++;
                return;
            end
            want = expected.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                failures++;
            end
            if (count !== want.count) begin
                $error("count: expected %0d, actual %0d", want.count, count);
                failures++;
            end
            if (read_value !== want.read_value) begin
                $error("read_value: expected %0d, actual %0d", want.read_value, read_value);
                failures++;
            end
        endfunction
    endclass

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    logic       i_clk;
    logic       i_rst_n;
    isl_req_if  req_ch();
    isl_rsp_if  rsp_ch();

    t_list_shadow book = new();
    int         send_idle_pct;
    int         rsp_stall_pct;
    int         cycle_count;

    indexed_sequential_list dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hold all block inputs at known values from time zero.
    initial begin
        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.func     = '0;
        req_ch.position = '0;
        req_ch.value    = '0;
        rsp_ch.ready    = 1'b0;
        send_idle_pct   = 0;
        rsp_stall_pct   = 0;
    end

    // Set ready at the falling edge; stall with the current probability.
    always @(negedge i_clk) begin
        rsp_ch.ready = ($urandom_range(99) >= rsp_stall_pct);
    end

    // Check every response taken at a rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
            book.check_response(rsp_ch.status, rsp_ch.count, rsp_ch.read_value);
        end
    end

    // Abort a hung run.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $error("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
               book.expected.size());
        $display("Some tests failed");
        $finish;
    end

    // Offer one request from a falling edge and hold it until the block takes it.
    task automatic push_request(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pos,
                                input logic signed [VAL_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid    = 1'b1;
        req_ch.func     = func;
        req_ch.position = pos;
        req_ch.value    = val;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        book.note_request(func, pos, val);
        @(negedge i_clk);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(19))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly a legal position, biased toward both ends; sometimes anything.
    function automatic logic [POS_W-1:0] pick_position(bit for_insert);
        int top;
        int r;
        top = for_insert ? book.n_entries + 1 : book.n_entries;
        if (top == 0 || $urandom_range(99) < 15) return POS_W'($urandom_range(63));
        r = $urandom_range(9);
        if (r == 0) return 1;
        if (r == 1) return POS_W'(top);
        return POS_W'($urandom_range(top, 1));
    endfunction

    task automatic run_random(input int n_items, input int idle_pct, input int stall_pct);
        t_mix                    mix;
        int                      ins_w;
        int                      del_w;
        int                      r;
        logic [FUNC_W-1:0]       func;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        mix = MIX_FILL;
        for (int i = 0; i < n_items; i++) begin
            // Reshuffle the blend now and then so the list both fills up and drains.
            if (i % 40 == 39) mix = t_mix'($urandom_range(2));
            case (mix)
                MIX_FILL:  begin ins_w = 60; del_w = 10; end
                MIX_DRAIN: begin ins_w = 15; del_w = 50; end
                default:   begin ins_w = 30; del_w = 25; end
            endcase
            r   = $urandom_range(99);
            val = pick_value();
            if (r < 1) begin
                func = F_CLEAR;
                pos  = POS_W'($urandom_range(63));
            end else if (r < 4) begin
                func = FUNC_W'($urandom_range(F_SPARE_HI, F_SPARE_LO));
                pos  = POS_W'($urandom_range(63));
            end else if (r < 4 + ins_w) begin
                func = F_INSERT;
                pos  = pick_position(1'b1);
            end else if (r < 4 + ins_w + del_w) begin
                func = F_DELETE;
                pos  = pick_position(1'b0);
            end else begin
                func = $urandom_range(1) ? F_UPDATE : F_READ;
                pos  = pick_position(1'b0);
            end
            push_request(func, pos, val);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty-list errors, bad insert positions, edge values,
        // insert at front/middle/end, reads past the end, undefined codes, clear.
        push_request(F_READ,   1, 0);
        push_request(F_DELETE, 1, 0);
        push_request(F_UPDATE, 1, 32'sh1234_5678);
        push_request(F_INSERT, 0, 32'sh1111_1111);
        push_request(F_INSERT, 2, 32'sh2222_2222);
        push_request(F_INSERT, 1, 32'sh8000_0000);
        push_request(F_INSERT, 2, 32'sh7fff_ffff);
        push_request(F_INSERT, 1, 0);
        push_request(F_INSERT, 2, -1);
        for (int p = 1; p <= 5; p++) push_request(F_READ, POS_W'(p), 0);
        push_request(F_UPDATE, 4, 32'sh5555_5555);
        push_request(F_UPDATE, 5, 32'sh0aaa_aaaa);
        push_request(F_INSERT, 6, 32'sh3333_3333);
        push_request(F_DELETE, 2, 0);
        push_request(F_DELETE, 3, 0);
        push_request(F_READ,   63, 0);
        push_request(F_SPARE_LO, 1, 32'sh4444_4444);
        push_request(F_SPARE_LO + FUNC_W'(1), 1, 0);
        push_request(F_SPARE_HI, 1, 0);
        push_request(F_CLEAR,  63, 32'sh7fff_ffff);
        push_request(F_READ,   1, 0);

        // Random phases: free-running, slow sender, slow receiver, both slow.
        run_random(160, 0, 0);
        run_random(160, 75, 0);
        run_random(160, 0, 75);
        run_random(170, 25, 25);

        req_ch.valid  = 1'b0;
        rsp_stall_pct = 0;
        while (book.expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (book.failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
